/* hw/rtl/assert_macros.svh */
// assertion macros for the rtl files
// each macro expects clk and rst in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/cffba_pkg.sv */
// types, codes and defaults for the contiguous first-fit block allocator
// no dependencies
package cffba_pkg;

  localparam int CFFBA_NUM_BLOCKS = 16;
  localparam int CFFBA_ID_BITS    = 8;
  localparam int MAX_RESULTS      = 16;
  localparam int PART_W           = 4;

  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_LIST  = 2'd2;
  localparam logic [1:0] ACT_RSVD  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXISTS    = 2'd1;
  localparam logic [1:0] ST_NO_SPACE  = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] file_id;
    logic [4:0] alloc_size;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] block_index;
    logic [3:0] partition_no;
    logic [4:0] run_length;
    logic [4:0] free_count;
    logic       last;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_SCAN,
    S_FILL,
    S_RUN,
    S_LRD,
    S_LEMIT,
    S_DONE
  } state_t;

endpackage

/* hw/rtl/cffba_ram.sv */
// generic single-port ram with registered read
// no dependencies
module cffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* hw/rtl/contiguous_first_fit_block_allocator_unit.sv */
// Contiguous first-fit block allocator. Takes one request at a time and walks the block map one
// block per cycle through a single-port ram that holds owner id and partition of each block;
// used marks and the free count sit in flip-flops. The owner search walks from block 0 up to
// the file's first block (the whole map when the file is absent). Allocate then scans the
// used marks for the first free run long enough and writes one block per cycle. Free follows
// the run from its first block and clears it on the way. List follows the run to measure it,
// restarts the read at its first block and emits result beats, up to MAX_RESULTS, as the
// output takes them. Every request but the reserved code, which gets no beat, ends with its
// last beat loaded into the output register; the next request is taken the cycle after.
// depends on cffba_pkg, cffba_ram and assert_macros.svh
`include "assert_macros.svh"

module contiguous_first_fit_block_allocator_unit
  import cffba_pkg::*;
#(
  parameter int NUM_BLOCKS = CFFBA_NUM_BLOCKS,
  parameter int ID_BITS    = CFFBA_ID_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int IW = $clog2(NUM_BLOCKS);
  localparam int CW = $clog2(NUM_BLOCKS + 1);
  localparam int EW = CW + 5;
  localparam int RW = ID_BITS + PART_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BLOCKS - 1);

  state_t                state, state_next;
  logic [IW-1:0]         ptr, ptr_next;
  logic [IW-1:0]         start, start_next;
  logic [CW-1:0]         cnt, cnt_next;
  logic [CW-1:0]         len, len_next;
  logic [4:0]            emit_cnt, emit_next;
  logic [1:0]            act, act_next;
  logic [ID_BITS-1:0]    id, id_next;
  logic [4:0]            size, size_next;
  logic [NUM_BLOCKS-1:0] used, used_next;
  logic [CW-1:0]         free_cnt, free_next;
  rsp_t                  res, res_next;
  logic                  rsp_valid_next;
  rsp_t                  rsp_next;

  logic [ID_BITS+7:0]    id_ext;
  logic [ID_BITS-1:0]    in_id;
  logic [IW-1:0]         ram_addr;
  logic                  ram_we;
  logic [RW-1:0]         ram_wdata;
  logic [RW-1:0]         ram_rdata;
  logic [ID_BITS-1:0]    rd_owner;
  logic [PART_W-1:0]     rd_part;
  logic [IW-1:0]         ptr_inc;
  logic                  is_end;
  logic                  hit;
  logic                  out_free;
  logic                  list_last;
  logic                  run_end;
  logic                  err_set;
  logic [1:0]            err_code;

  assign id_ext   = {{ID_BITS{1'b0}}, req.file_id};
  assign in_id    = id_ext[ID_BITS-1:0];
  assign rd_owner = ram_rdata[RW-1:PART_W];
  assign rd_part  = ram_rdata[PART_W-1:0];
  assign is_end   = (ptr == LAST_IDX);
  assign ptr_inc  = is_end ? '0 : ptr + 1'b1;
  assign hit      = used[ptr] && (rd_owner == id);
  assign out_free = !rsp_valid || !rsp_stall;
  assign list_last = ((EW'(emit_cnt) + 1'b1) == EW'(len)) ||
                     (emit_cnt == 5'(MAX_RESULTS - 1));
  assign req_stall = (state != S_IDLE);

  cffba_ram #(
    .WIDTH (RW),
    .DEPTH (NUM_BLOCKS)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next     = state;
    ptr_next       = ptr;
    start_next     = start;
    cnt_next       = cnt;
    len_next       = len;
    emit_next      = emit_cnt;
    act_next       = act;
    id_next        = id;
    size_next      = size;
    used_next      = used;
    free_next      = free_cnt;
    res_next       = res;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next       = rsp;
    ram_addr       = ptr;
    ram_we         = 1'b0;
    ram_wdata      = {id, PART_W'(cnt)};
    run_end        = 1'b0;
    err_set        = 1'b0;
    err_code       = ST_NOT_FOUND;

    unique case (state)
      S_IDLE: begin
        ram_addr = '0;
        if (req_valid) begin
          act_next  = req.action;
          id_next   = in_id;
          size_next = req.alloc_size;
          ptr_next  = '0;
          if (req.action != ACT_RSVD) begin
            state_next = S_FIND;
          end
        end
      end

      // lowest block owned by the id, one block per cycle
      S_FIND: begin
        ram_addr = ptr_inc;
        if (hit) begin
          start_next = ptr;
          if (act == ACT_ALLOC) begin
            err_set  = 1'b1;
            err_code = ST_EXISTS;
          end else begin
            len_next = CW'(1);
            if (act == ACT_FREE) begin
              used_next[ptr] = 1'b0;
              free_next      = free_cnt + 1'b1;
            end
            if (is_end) begin
              run_end = 1'b1;
            end else begin
              ptr_next   = ptr_inc;
              state_next = S_RUN;
            end
          end
        end else if (is_end) begin
          if (act == ACT_ALLOC && size != 5'd0) begin
            ptr_next   = '0;
            cnt_next   = '0;
            state_next = S_SCAN;
          end else begin
            err_set  = 1'b1;
            err_code = (act == ACT_ALLOC) ? ST_NO_SPACE : ST_NOT_FOUND;
          end
        end else begin
          ptr_next = ptr_inc;
        end
      end

      // first free run long enough
      S_SCAN: begin
        if (!used[ptr]) begin
          if (cnt == '0) begin
            start_next = ptr;
          end
          cnt_next = cnt + 1'b1;
          if ((EW'(cnt) + 1'b1) == EW'(size)) begin
            ptr_next   = start_next;
            cnt_next   = '0;
            state_next = S_FILL;
          end else if (is_end) begin
            err_set  = 1'b1;
            err_code = ST_NO_SPACE;
          end else begin
            ptr_next = ptr_inc;
          end
        end else begin
          cnt_next = '0;
          if (is_end) begin
            err_set  = 1'b1;
            err_code = ST_NO_SPACE;
          end else begin
            ptr_next = ptr_inc;
          end
        end
      end

      // cnt doubles as partition number here
      S_FILL: begin
        ram_we         = 1'b1;
        used_next[ptr] = 1'b1;
        free_next      = free_cnt - 1'b1;
        if ((EW'(cnt) + 1'b1) == EW'(size)) begin
          res_next.status       = ST_OK;
          res_next.block_index  = 4'(start);
          res_next.partition_no = '0;
          res_next.run_length   = size;
          res_next.free_count   = 5'(free_next);
          res_next.last         = 1'b1;
          state_next            = S_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
          ptr_next = ptr_inc;
        end
      end

      // follow the run; free clears it on the way
      S_RUN: begin
        ram_addr = ptr_inc;
        if (hit) begin
          len_next = len + 1'b1;
          if (act == ACT_FREE) begin
            used_next[ptr] = 1'b0;
            free_next      = free_cnt + 1'b1;
          end
          if (is_end) begin
            run_end = 1'b1;
          end else begin
            ptr_next = ptr_inc;
          end
        end else begin
          run_end = 1'b1;
        end
      end

      S_LRD: begin
        ram_addr   = ptr;
        state_next = S_LEMIT;
      end

      S_LEMIT: begin
        ram_addr = ptr;
        if (out_free) begin
          rsp_valid_next        = 1'b1;
          rsp_next.status       = ST_OK;
          rsp_next.block_index  = 4'(ptr);
          rsp_next.partition_no = rd_part;
          rsp_next.run_length   = 5'(len);
          rsp_next.free_count   = 5'(free_cnt);
          rsp_next.last         = list_last;
          if (list_last) begin
            state_next = S_IDLE;
          end else begin
            emit_next = emit_cnt + 1'b1;
            ptr_next  = ptr_inc;
            ram_addr  = ptr_inc;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          rsp_valid_next = 1'b1;
          rsp_next       = res;
          state_next     = S_IDLE;
        end
      end
    endcase

    if (run_end) begin
      if (act == ACT_FREE) begin
        res_next.status       = ST_OK;
        res_next.block_index  = 4'(start_next);
        res_next.partition_no = '0;
        res_next.run_length   = 5'(len_next);
        res_next.free_count   = 5'(free_next);
        res_next.last         = 1'b1;
        state_next            = S_DONE;
      end else begin
        ptr_next   = start_next;
        emit_next  = '0;
        state_next = S_LRD;
      end
    end

    if (err_set) begin
      res_next.status       = err_code;
      res_next.block_index  = '0;
      res_next.partition_no = '0;
      res_next.run_length   = '0;
      res_next.free_count   = 5'(free_next);
      res_next.last         = 1'b1;
      state_next            = S_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      free_cnt  <= CW'(NUM_BLOCKS);
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      used      <= used_next;
      free_cnt  <= free_next;
      rsp_valid <= rsp_valid_next;
    end
    ptr      <= ptr_next;
    start    <= start_next;
    cnt      <= cnt_next;
    len      <= len_next;
    emit_cnt <= emit_next;
    act      <= act_next;
    id       <= id_next;
    size     <= size_next;
    res      <= res_next;
    rsp      <= rsp_next;
  end

  `AST_IMP(a_free_count_tracks_map, 1'b1, ($countones(used) + free_cnt) == NUM_BLOCKS)
  `AST_IMP(a_fill_hits_free_block, state == S_FILL, !used[ptr])
  `AST_IMP(a_only_list_continues, rsp_valid && !rsp.last, rsp.status == ST_OK)
  `AST_NXT(a_list_steps_run, state == S_LEMIT && out_free && !list_last, ptr == $past(ptr_inc))

endmodule

/* tb/sv/cffba_checker.sv */
`timescale 1ns / 100ps
// checker for the contiguous first-fit block allocator: watches both channels,
// keeps its own copy of the block map and compares every response beat
// depends on cffba_pkg
module cffba_checker
  import cffba_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   mismatches,
  output int   reports_due
);

  localparam int         NB      = CFFBA_NUM_BLOCKS;
  localparam logic [7:0] ID_MASK = 8'((1 << CFFBA_ID_BITS) - 1);

  logic       blk_used  [NB];
  logic [7:0] blk_owner [NB];
  logic [3:0] blk_part  [NB];
  rsp_t       due_beats [$];
  int         fail_count = 0;

  task automatic report_error(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_error($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  function automatic int free_blocks();
    int n = 0;
    for (int i = 0; i < NB; i++) if (!blk_used[i]) n++;
    return n;
  endfunction

  // free count is taken after the map update, as the block reports it
  function automatic void expect_beat(input logic [1:0] st, input int blk, input int part,
                                      input int len, input bit last);
    rsp_t b;
    b.status       = st;
    b.block_index  = blk[3:0];
    b.partition_no = part[3:0];
    b.run_length   = len[4:0];
    b.free_count   = 5'(free_blocks());
    b.last         = last;
    due_beats.insert(due_beats.size(), b);
  endfunction

  task automatic update_block_map(input req_t r);
    logic [7:0] id;
    int         first, start, cnt, len, n;
    bit         found;
    id    = r.file_id & ID_MASK;
    first = -1;
    for (int i = NB - 1; i >= 0; i--)
      if (blk_used[i] && blk_owner[i] == id) first = i;
    if (r.action == ACT_RSVD) begin
      // ignored code: no beat and no change
    end else if (r.action == ACT_ALLOC) begin
      if (first >= 0) begin
        expect_beat(ST_EXISTS, 0, 0, 0, 1'b1);
      end else begin
        cnt   = 0;
        start = 0;
        found = 1'b0;
        for (int i = 0; i < NB && r.alloc_size != 0 && !found; i++) begin
          if (!blk_used[i]) begin
            if (cnt == 0) start = i;
            cnt++;
            if (cnt == r.alloc_size) found = 1'b1;
          end else begin
            cnt = 0;
          end
        end
        if (!found) begin
          expect_beat(ST_NO_SPACE, 0, 0, 0, 1'b1);
        end else begin
          for (int i = 0; i < r.alloc_size; i++) begin
            blk_used[start + i]  = 1'b1;
            blk_owner[start + i] = id;
            blk_part[start + i]  = 4'(i);
          end
          expect_beat(ST_OK, start, 0, r.alloc_size, 1'b1);
        end
      end
    end else if (first < 0) begin
      expect_beat(ST_NOT_FOUND, 0, 0, 0, 1'b1);
    end else begin
      len = 0;
      while (first + len < NB && blk_used[first + len] && blk_owner[first + len] == id) len++;
      if (r.action == ACT_FREE) begin
        for (int i = first; i < first + len; i++) blk_used[i] = 1'b0;
        expect_beat(ST_OK, first, 0, len, 1'b1);
      end else begin
        n = (len > MAX_RESULTS) ? MAX_RESULTS : len;
        for (int i = 0; i < n; i++)
          expect_beat(ST_OK, first + i, blk_part[first + i], len, i == n - 1);
      end
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < NB; i++) begin
        blk_used[i]  = 1'b0;
        blk_owner[i] = '0;
        blk_part[i]  = '0;
      end
      due_beats.delete();
    end else begin
      // a response beat can share an edge with the next request, so pop first
      if (rsp_valid && !rsp_stall) begin
        if (due_beats.size() == 0) begin
          report_error($sformatf("beat with nothing due: %p", rsp));
        end else begin
          want = due_beats.pop_front();
          check_field("status", rsp.status, want.status);
          check_field("block_index", rsp.block_index, want.block_index);
          check_field("partition_no", rsp.partition_no, want.partition_no);
          check_field("run_length", rsp.run_length, want.run_length);
          check_field("free_count", rsp.free_count, want.free_count);
          check_field("last", rsp.last, want.last);
        end
      end
      if (req_valid && !req_stall) update_block_map(req);
    end
    reports_due <= due_beats.size();
    mismatches  <= fail_count;
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// top of the block allocator testbench: clock, reset, request beats and response stalls
// depends on cffba_pkg, cffba_checker and contiguous_first_fit_block_allocator_unit
module tb_top;
  import cffba_pkg::*;

  localparam int RANDOM_ITEMS = 195;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 100;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  int         mismatches;
  int         reports_due;
  int         idle_cycles = 0;
  int         stall_left  = 0;
  bit         steady      = 1'b0;
  logic [7:0] id_pool [10];

  contiguous_first_fit_block_allocator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  cffba_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .reports_due (reports_due)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // response side: runs of stall, mostly short with the odd long one
  always @(posedge clk) begin
    if (steady) begin
      rsp_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 2) != 0) begin
      rsp_stall  <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      rsp_stall  <= 1'b1;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_cmd(input logic [1:0] act, input logic [7:0] id, input logic [4:0] size);
    int gap;
    int roll;
    req       <= '{action: act, file_id: id, alloc_size: size};
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    roll = $urandom_range(0, 99);
    if (steady || roll < 60) gap = 0;
    else if (roll < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 50);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
  endtask

  initial begin
    int         made;
    int         roll;
    bit         paused;
    logic [1:0] act;
    logic [7:0] id;
    logic [4:0] size;
    foreach (id_pool[k]) id_pool[k] = 8'($urandom_range(0, 255));
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // edges of the map: zero size, whole map, full list, duplicate and unknown ids
    send_cmd(ACT_ALLOC, 8'h00, 5'd0);
    send_cmd(ACT_ALLOC, 8'hff, 5'd16);
    send_cmd(ACT_LIST,  8'hff, 5'd0);
    send_cmd(ACT_ALLOC, 8'h01, 5'd1);
    send_cmd(ACT_ALLOC, 8'hff, 5'd3);
    send_cmd(ACT_FREE,  8'hff, 5'd0);
    send_cmd(ACT_FREE,  8'hff, 5'd0);
    send_cmd(ACT_LIST,  8'h5a, 5'd0);
    send_cmd(ACT_RSVD,  8'haa, 5'd31);
    // fragmentation: a hole too small, oversize requests, then first fit into holes
    send_cmd(ACT_ALLOC, 8'h11, 5'd4);
    send_cmd(ACT_ALLOC, 8'h22, 5'd4);
    send_cmd(ACT_ALLOC, 8'h33, 5'd4);
    send_cmd(ACT_FREE,  8'h22, 5'd0);
    send_cmd(ACT_ALLOC, 8'h44, 5'd5);
    send_cmd(ACT_ALLOC, 8'h44, 5'd31);
    send_cmd(ACT_ALLOC, 8'h55, 5'd3);
    send_cmd(ACT_ALLOC, 8'h66, 5'd2);
    send_cmd(ACT_LIST,  8'h55, 5'd0);
    send_cmd(ACT_LIST,  8'h33, 5'd0);
    send_cmd(ACT_ALLOC, 8'h00, 5'd1);
    send_cmd(ACT_FREE,  8'h11, 5'd0);
    send_cmd(ACT_FREE,  8'h33, 5'd0);
    send_cmd(ACT_FREE,  8'h55, 5'd0);
    send_cmd(ACT_FREE,  8'h66, 5'd0);
    send_cmd(ACT_FREE,  8'h00, 5'd0);
    wait_drained();

    made   = 0;
    paused = 1'b0;
    while (made < RANDOM_ITEMS) begin
      steady <= (made >= 80 && made < 120);
      if (made == 150 && !paused) begin
        paused = 1'b1;
        wait_drained();
      end
      roll = $urandom_range(0, 99);
      if (roll < 45) act = ACT_ALLOC;
      else if (roll < 68) act = ACT_FREE;
      else if (roll < 95) act = ACT_LIST;
      else act = ACT_RSVD;
      // a small pool of ids keeps files alive long enough to list and free
      if ($urandom_range(0, 4) == 0) id = 8'($urandom_range(0, 255));
      else id = id_pool[$urandom_range(0, 9)];
      roll = $urandom_range(0, 99);
      if (roll < 5) size = 5'd0;
      else if (roll < 75) size = 5'($urandom_range(1, 5));
      else if (roll < 92) size = 5'($urandom_range(6, 16));
      else size = 5'($urandom_range(17, 31));
      send_cmd(act, id, size);
      made++;
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && reports_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
